// ----- rtl/fdtd_pkg.sv -----
// shared types, constants and helper functions for the fdtd electric field update
package fdtd_pkg;

  localparam int unsigned FP_W     = 32;
  localparam int unsigned EXP_W    = 12;
  localparam int unsigned FMA_LAT  = 8;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDXW = 3;

  localparam logic [FP_W-1:0] QNAN     = 32'h7FC0_0000;
  localparam logic [FP_W-1:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [FP_W-1:0] NEG_ZERO = 32'h8000_0000;

  // register indexes
  localparam logic [CFG_IDXW-1:0] CFG_DECAY_X_Y       = 3'd0;
  localparam logic [CFG_IDXW-1:0] CFG_DECAY_Z_DRIVE_X = 3'd1;
  localparam logic [CFG_IDXW-1:0] CFG_DRIVE_Y_Z       = 3'd2;
  localparam logic [CFG_IDXW-1:0] CFG_DAMP_CUR        = 3'd3;
  localparam logic [CFG_IDXW-1:0] CFG_CURL_X          = 3'd4;
  localparam logic [CFG_IDXW-1:0] CFG_CURL_Y          = 3'd5;
  localparam logic [CFG_IDXW-1:0] CFG_CURL_Z          = 3'd6;

  typedef logic signed [EXP_W-1:0] exp_t;

  // exponent given to a zero addend so that it always aligns below the product
  localparam exp_t EXP_ZERO_C = -12'sd512;

  typedef struct packed {
    logic            sign;
    logic            zero;
    logic            inf;
    logic            nan;
    logic [23:0]     mant;
    exp_t            expo;
  } unp_t;

  typedef struct packed {
    logic            hit;
    logic [FP_W-1:0] bits;
  } spec_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc52(input logic [51:0] v);
    logic [5:0] n;
    n = 6'd52;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) n = 6'(51 - i);
    end
    return n;
  endfunction

  // unpack and normalize a single so that the mantissa msb is set for every nonzero value
  function automatic unp_t fp_unpack(input logic [FP_W-1:0] x);
    unp_t       u;
    logic [4:0] lz;
    logic [23:0] m;
    m      = {(x[30:23] != 8'd0), x[22:0]};
    lz     = lzc24(m);
    u.sign = x[31];
    u.zero = (x[30:23] == 8'd0) && (x[22:0] == 23'd0);
    u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    u.mant = m << lz;
    u.expo = ((x[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, x[30:23]}))
             - $signed({7'd0, lz});
    return u;
  endfunction

endpackage

// ----- rtl/fdtd_electric_field_update.sv -----
// Yee-grid electric field update for one voxel per transaction, single precision.
// Each axis runs through seven chained fused multiply-add levels (difference, product,
// curl, damping, current, drive, decay), each an eight stage unit, then one output
// register stage. One voxel is accepted every cycle while the skid is empty; the rate
// is set by the fully pipelined fused multiply-add units. A one entry skid buffer
// behind the output register catches a result on a stall, closing the input. The user
// must write coefficient registers via the cfg port while idle; it is not enforced.
module fdtd_electric_field_update
  import fdtd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // e_x_y, e_z_curl_x, curl_y_z, b_x_y, b_z_j_x, j_y_z, xnext_b_y_z, ynext_b_x_z,
  // znext_b_x_y, 64 bits each from the lowest bit up
  input  logic [575:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // new_ex, new_ey, new_ez, new_tca_x, new_tca_y, new_tca_z, 32 bits each from bit 0
  output logic [191:0]        m_axis_tdata
);

  logic [CFG_W-1:0] decay_xy_q, decay_z_drv_x_q, drive_yz_q, damp_cur_q;
  logic [CFG_W-1:0] curl_x_q, curl_y_q, curl_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_xy_q      <= '0;
      decay_z_drv_x_q <= '0;
      drive_yz_q      <= '0;
      damp_cur_q      <= '0;
      curl_x_q        <= '0;
      curl_y_q        <= '0;
      curl_z_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DECAY_X_Y:       decay_xy_q      <= cfg_wdata_i;
        CFG_DECAY_Z_DRIVE_X: decay_z_drv_x_q <= cfg_wdata_i;
        CFG_DRIVE_Y_Z:       drive_yz_q      <= cfg_wdata_i;
        CFG_DAMP_CUR:        damp_cur_q      <= cfg_wdata_i;
        CFG_CURL_X:          curl_x_q        <= cfg_wdata_i;
        CFG_CURL_Y:          curl_y_q        <= cfg_wdata_i;
        CFG_CURL_Z:          curl_z_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline enable and output side
  logic            en, in_acc;
  logic            out_v_q, skid_v_q;
  logic [191:0]    out_q, skid_q;
  logic            pipe_v;
  logic [191:0]    pipe_data;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  // operand lanes
  logic [FP_W-1:0] d1_a [3], d1_b [3], d2_a [3], d2_b [3];
  logic [FP_W-1:0] tca_in [3], j_in [3], e_in [3];
  logic [FP_W-1:0] p1 [3], p2 [3], dc [3], dr [3];
  logic [FP_W-1:0] damp, cj;

  always_comb begin
    e_in[0]   = s_axis_tdata[31:0];
    e_in[1]   = s_axis_tdata[63:32];
    e_in[2]   = s_axis_tdata[95:64];
    tca_in[0] = s_axis_tdata[127:96];
    tca_in[1] = s_axis_tdata[159:128];
    tca_in[2] = s_axis_tdata[191:160];
    j_in[0]   = s_axis_tdata[319:288];
    j_in[1]   = s_axis_tdata[351:320];
    j_in[2]   = s_axis_tdata[383:352];
    // x: (bz - ybz), (by - zby)
    d1_a[0] = s_axis_tdata[287:256];  d1_b[0] = s_axis_tdata[511:480];
    d2_a[0] = s_axis_tdata[255:224];  d2_b[0] = s_axis_tdata[575:544];
    // y: (bx - zbx), (bz - xbz)
    d1_a[1] = s_axis_tdata[223:192];  d1_b[1] = s_axis_tdata[543:512];
    d2_a[1] = s_axis_tdata[287:256];  d2_b[1] = s_axis_tdata[447:416];
    // z: (by - xby), (bx - ybx)
    d1_a[2] = s_axis_tdata[255:224];  d1_b[2] = s_axis_tdata[415:384];
    d2_a[2] = s_axis_tdata[223:192];  d2_b[2] = s_axis_tdata[479:448];
    p1[0] = curl_x_q[31:0];  p2[0] = curl_x_q[63:32];
    p1[1] = curl_y_q[31:0];  p2[1] = curl_y_q[63:32];
    p1[2] = curl_z_q[31:0];  p2[2] = curl_z_q[63:32];
    dc[0] = decay_xy_q[31:0];
    dc[1] = decay_xy_q[63:32];
    dc[2] = decay_z_drv_x_q[31:0];
    dr[0] = decay_z_drv_x_q[63:32];
    dr[1] = drive_yz_q[31:0];
    dr[2] = drive_yz_q[63:32];
    damp  = damp_cur_q[31:0];
    cj    = damp_cur_q[63:32];
  end

  logic [FP_W-1:0] d1_w [3], d2_w [3], m_w [3], s_w [3], nt_w [3], u_w [3], w_w [3];
  logic [FP_W-1:0] ne_w [3];
  logic [FP_W-1:0] d1_dl [3], tca_dl [3], j_dl [3], e_dl [3], nt_dl [3];
  logic [2:0]      v1a, v1b, v2, v3, v4, v5, v6, v7;
  logic            lv1, lv2, lv3, lv4, lv5, lv6;

  assign lv1 = &v1a & &v1b;
  assign lv2 = &v2;
  assign lv3 = &v3;
  assign lv4 = &v4;
  assign lv5 = &v5;
  assign lv6 = &v6;

  logic [3*FP_W-1:0] d1_pk, d1_dpk, tca_pk, tca_dpk, j_pk, j_dpk, e_pk, e_dpk;
  logic [3*FP_W-1:0] nt_pk, nt_dpk;

  assign d1_pk  = {d1_w[2], d1_w[1], d1_w[0]};
  assign tca_pk = {tca_in[2], tca_in[1], tca_in[0]};
  assign j_pk   = {j_in[2], j_in[1], j_in[0]};
  assign e_pk   = {e_in[2], e_in[1], e_in[0]};
  assign nt_pk  = {nt_w[2], nt_w[1], nt_w[0]};

  fdtd_dly #(.DEPTH(FMA_LAT),     .WIDTH(3*FP_W)) u_dly_d1
    (.clk_i(clk_i), .en_i(en), .d_i(d1_pk), .q_o(d1_dpk));
  fdtd_dly #(.DEPTH(3*FMA_LAT),   .WIDTH(3*FP_W)) u_dly_tca
    (.clk_i(clk_i), .en_i(en), .d_i(tca_pk), .q_o(tca_dpk));
  fdtd_dly #(.DEPTH(4*FMA_LAT),   .WIDTH(3*FP_W)) u_dly_j
    (.clk_i(clk_i), .en_i(en), .d_i(j_pk), .q_o(j_dpk));
  fdtd_dly #(.DEPTH(6*FMA_LAT),   .WIDTH(3*FP_W)) u_dly_e
    (.clk_i(clk_i), .en_i(en), .d_i(e_pk), .q_o(e_dpk));
  fdtd_dly #(.DEPTH(3*FMA_LAT),   .WIDTH(3*FP_W)) u_dly_nt
    (.clk_i(clk_i), .en_i(en), .d_i(nt_pk), .q_o(nt_dpk));

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    assign d1_dl[ax]  = d1_dpk[ax*FP_W +: FP_W];
    assign tca_dl[ax] = tca_dpk[ax*FP_W +: FP_W];
    assign j_dl[ax]   = j_dpk[ax*FP_W +: FP_W];
    assign e_dl[ax]   = e_dpk[ax*FP_W +: FP_W];
    assign nt_dl[ax]  = nt_dpk[ax*FP_W +: FP_W];

    // differences as x*1 - y
    fdtd_fma u_sub1 (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(in_acc),
      .a_i(d1_a[ax]), .b_i(FP_ONE), .c_i({~d1_b[ax][31], d1_b[ax][30:0]}),
      .neg_prod_i(1'b0), .valid_o(v1a[ax]), .res_o(d1_w[ax]));
    fdtd_fma u_sub2 (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(in_acc),
      .a_i(d2_a[ax]), .b_i(FP_ONE), .c_i({~d2_b[ax][31], d2_b[ax][30:0]}),
      .neg_prod_i(1'b0), .valid_o(v1b[ax]), .res_o(d2_w[ax]));
    // plain product as p*d + (-0)
    fdtd_fma u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(lv1),
      .a_i(p2[ax]), .b_i(d2_w[ax]), .c_i(NEG_ZERO),
      .neg_prod_i(1'b0), .valid_o(v2[ax]), .res_o(m_w[ax]));
    fdtd_fma u_curl (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(lv2),
      .a_i(p1[ax]), .b_i(d1_dl[ax]), .c_i({~m_w[ax][31], m_w[ax][30:0]}),
      .neg_prod_i(1'b0), .valid_o(v3[ax]), .res_o(s_w[ax]));
    fdtd_fma u_damp (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(lv3),
      .a_i(damp), .b_i(tca_dl[ax]), .c_i(s_w[ax]),
      .neg_prod_i(1'b1), .valid_o(v4[ax]), .res_o(nt_w[ax]));
    fdtd_fma u_cur (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(lv4),
      .a_i(cj), .b_i(j_dl[ax]), .c_i(nt_w[ax]),
      .neg_prod_i(1'b1), .valid_o(v5[ax]), .res_o(u_w[ax]));
    fdtd_fma u_drv (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(lv5),
      .a_i(dr[ax]), .b_i(u_w[ax]), .c_i(NEG_ZERO),
      .neg_prod_i(1'b0), .valid_o(v6[ax]), .res_o(w_w[ax]));
    fdtd_fma u_upd (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(lv6),
      .a_i(dc[ax]), .b_i(e_dl[ax]), .c_i(w_w[ax]),
      .neg_prod_i(1'b0), .valid_o(v7[ax]), .res_o(ne_w[ax]));
  end

  assign pipe_v    = &v7;
  assign pipe_data = {nt_dl[2], nt_dl[1], nt_dl[0], ne_w[2], ne_w[1], ne_w[0]};

  // output register with one entry skid
  logic take;
  assign take = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      out_v_q  <= skid_v_q || pipe_v;
      skid_v_q <= 1'b0;
    end else if (pipe_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : pipe_data;
    end else if (pipe_v && en) begin
      skid_q <= pipe_data;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid filled while output was free");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> m_axis_tvalid)
    else $error("skid holds a transaction with no output pending");

  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0))
    |-> (m_axis_tdata[31:0] == QNAN))
    else $error("non canonical nan on new_ex");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7 == 3'b000) || (v7 == 3'b111))
    else $error("axis lanes out of step");
`endif

endmodule

// ----- rtl/fdtd_dly.sv -----
// payload delay line that advances with the pipeline enable
module fdtd_dly #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 96
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ----- rtl/fdtd_fma.sv -----
// eight stage fused multiply-add, single precision, round to nearest even
module fdtd_fma
  import fdtd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [FP_W-1:0] a_i,
  input  logic [FP_W-1:0] b_i,
  input  logic [FP_W-1:0] c_i,
  input  logic            neg_prod_i,
  output logic            valid_o,
  output logic [FP_W-1:0] res_o
);

  logic [FMA_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FMA_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[FMA_LAT-1];

  // stage 1: unpack, normalize, special values
  unp_t  ua, ub, uc;
  logic  sp_d, prod_inf, prod_zero;
  spec_t spc_d;

  always_comb begin
    ua        = fp_unpack(a_i);
    ub        = fp_unpack(b_i);
    uc        = fp_unpack(c_i);
    sp_d      = ua.sign ^ ub.sign ^ neg_prod_i;
    prod_inf  = ua.inf | ub.inf;
    prod_zero = ua.zero | ub.zero;
    if (ua.nan || ub.nan || uc.nan || (ua.inf && ub.zero) || (ub.inf && ua.zero) ||
        (prod_inf && uc.inf && (sp_d != uc.sign))) begin
      spc_d = '{hit: 1'b1, bits: QNAN};
    end else if (prod_inf) begin
      spc_d = '{hit: 1'b1, bits: {sp_d, 8'hFF, 23'd0}};
    end else if (uc.inf) begin
      spc_d = '{hit: 1'b1, bits: c_i};
    end else if (prod_zero) begin
      spc_d = '{hit: 1'b1, bits: uc.zero ? {sp_d & uc.sign, 31'd0} : c_i};
    end else begin
      spc_d = '{hit: 1'b0, bits: '0};
    end
  end

  logic [23:0] s1_ma_q, s1_mb_q, s1_mc_q;
  exp_t        s1_ea_q, s1_eb_q, s1_ec_q;
  logic        s1_sp_q, s1_sc_q;
  spec_t       s1_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ma_q  <= ua.mant;
      s1_mb_q  <= ub.mant;
      s1_mc_q  <= uc.mant;
      s1_ea_q  <= ua.expo;
      s1_eb_q  <= ub.expo;
      s1_ec_q  <= uc.zero ? EXP_ZERO_C : uc.expo;
      s1_sp_q  <= sp_d;
      s1_sc_q  <= uc.sign;
      s1_spc_q <= spc_d;
    end
  end

  // stage 2: significand product
  logic [47:0] s2_prod_q;
  logic [23:0] s2_mc_q;
  exp_t        s2_ep_q, s2_ec_q;
  logic        s2_sp_q, s2_sc_q;
  spec_t       s2_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_prod_q <= s1_ma_q * s1_mb_q;
      s2_ep_q   <= s1_ea_q + s1_eb_q - 12'sd127;
      s2_ec_q   <= s1_ec_q;
      s2_mc_q   <= s1_mc_q;
      s2_sp_q   <= s1_sp_q;
      s2_sc_q   <= s1_sc_q;
      s2_spc_q  <= s1_spc_q;
    end
  end

  // stage 3: align the smaller operand, jam shifted-out bits into the lsb
  exp_t        ediff;
  logic        p_big;
  logic [11:0] amt;
  logic [5:0]  sh;
  logic [47:0] big_m, small_m;
  logic [50:0] small_ext, small_mask, small_al_d;

  always_comb begin
    ediff      = s2_ep_q - s2_ec_q;
    p_big      = ~ediff[EXP_W-1];
    amt        = p_big ? unsigned'(ediff) : unsigned'(-ediff);
    sh         = (amt > 12'd63) ? 6'd63 : amt[5:0];
    big_m      = p_big ? s2_prod_q : {s2_mc_q, 23'd0};
    small_m    = p_big ? {s2_mc_q, 23'd0} : s2_prod_q;
    small_ext  = {small_m, 3'd0};
    small_mask = (sh >= 6'd51) ? '1 : ((51'd1 << sh) - 51'd1);
    small_al_d = (small_ext >> sh) | {50'd0, |(small_ext & small_mask)};
  end

  logic [50:0] s3_big_q, s3_small_q;
  exp_t        s3_e_q;
  logic        s3_sgn_q, s3_sub_q;
  spec_t       s3_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_big_q   <= {big_m, 3'd0};
      s3_small_q <= small_al_d;
      s3_e_q     <= p_big ? s2_ep_q : s2_ec_q;
      s3_sgn_q   <= p_big ? s2_sp_q : s2_sc_q;
      s3_sub_q   <= s2_sp_q ^ s2_sc_q;
      s3_spc_q   <= s2_spc_q;
    end
  end

  // stage 4: add or subtract magnitudes
  logic [51:0] sum_w, dif_w, mag_w;

  always_comb begin
    sum_w = {1'b0, s3_big_q} + {1'b0, s3_small_q};
    dif_w = {1'b0, s3_big_q} - {1'b0, s3_small_q};
    mag_w = dif_w[51] ? (52'd0 - dif_w) : dif_w;
  end

  logic [51:0] s4_s_q;
  exp_t        s4_e_q;
  logic        s4_sign_q;
  spec_t       s4_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_s_q    <= s3_sub_q ? mag_w : sum_w;
      s4_e_q    <= s3_e_q;
      s4_sign_q <= s3_sgn_q ^ (s3_sub_q & dif_w[51]);
      s4_spc_q  <= s3_spc_q;
    end
  end

  // stage 5: leading zero count
  logic [51:0] s5_s_q;
  logic [5:0]  s5_lz_q;
  exp_t        s5_e_q;
  logic        s5_sign_q, s5_zero_q;
  spec_t       s5_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_s_q    <= s4_s_q;
      s5_lz_q   <= lzc52(s4_s_q);
      s5_zero_q <= (s4_s_q == 52'd0);
      s5_e_q    <= s4_e_q;
      s5_sign_q <= s4_sign_q;
      s5_spc_q  <= s4_spc_q;
    end
  end

  // stage 6: normalize
  logic [51:0] s6_sn_q;
  exp_t        s6_e_q;
  logic        s6_sign_q, s6_zero_q;
  spec_t       s6_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_sn_q   <= s5_s_q << s5_lz_q;
      s6_e_q    <= s5_e_q - $signed({6'd0, s5_lz_q}) + 12'sd2;
      s6_sign_q <= s5_sign_q;
      s6_zero_q <= s5_zero_q;
      s6_spc_q  <= s5_spc_q;
    end
  end

  // stage 7: subnormal shift, guard and sticky
  logic        den;
  logic [11:0] rsh_full;
  logic [5:0]  rsh;
  logic [51:0] sd, den_mask;

  always_comb begin
    den      = (s6_e_q < 12'sd1);
    rsh_full = unsigned'(12'sd1 - s6_e_q);
    rsh      = !den ? 6'd0 : ((rsh_full > 12'd63) ? 6'd63 : rsh_full[5:0]);
    den_mask = (rsh >= 6'd52) ? '1 : ((52'd1 << rsh) - 52'd1);
    sd       = s6_sn_q >> rsh;
  end

  logic [7:0]  s7_expf_q;
  logic [22:0] s7_frac_q;
  logic        s7_g_q, s7_st_q, s7_ovf_q, s7_sign_q, s7_zero_q;
  spec_t       s7_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s7_expf_q <= den ? 8'd0 : s6_e_q[7:0];
      s7_ovf_q  <= !den && (s6_e_q > 12'sd254);
      s7_frac_q <= sd[50:28];
      s7_g_q    <= sd[27];
      s7_st_q   <= (|sd[26:0]) | (|(s6_sn_q & den_mask));
      s7_sign_q <= s6_sign_q;
      s7_zero_q <= s6_zero_q;
      s7_spc_q  <= s6_spc_q;
    end
  end

  // stage 8: round and pack, a carry out of the fraction bumps the exponent
  logic        inc;
  logic [30:0] word;

  always_comb begin
    inc  = s7_g_q & (s7_st_q | s7_frac_q[0]);
    word = {s7_expf_q, s7_frac_q} + {30'd0, inc};
  end

  logic [FP_W-1:0] s8_res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (s7_spc_q.hit) begin
        s8_res_q <= s7_spc_q.bits;
      end else if (s7_zero_q) begin
        s8_res_q <= 32'd0;
      end else if (s7_ovf_q) begin
        s8_res_q <= {s7_sign_q, 8'hFF, 23'd0};
      end else begin
        s8_res_q <= {s7_sign_q, word};
      end
    end
  end

  assign res_o = s8_res_q;

endmodule
